// ----- hdl/lru_key_value_cache_with_ttl_core_defines.svh -----
// Assertion macros shared by the checker.
`ifndef LRU_KEY_VALUE_CACHE_WITH_TTL_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_WITH_TTL_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define LKV_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/lkv_pkg.sv -----
package lkv_pkg;
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF = 32;
	localparam int VALUE_BITS_DEF = 64;
	localparam int TIME_BITS = 48;
	localparam int TTL_BITS = 41;
	localparam int CAP_BITS = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	localparam logic [1:0] ACT_SET = 2'd0;
	localparam logic [1:0] ACT_GET = 2'd1;
	localparam logic [1:0] ACT_DEL = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;
endpackage

// ----- hdl/lkv_ctrl.sv -----
module lkv_ctrl
	import lkv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);
	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) state_d = in_valid ? S_EXEC : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_EXEC: cmd.exec = 1'b1;
			S_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
			end
			default: ;
		endcase
		cmd.load = in_valid & in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// ----- hdl/lkv_datapath.sv -----
module lkv_datapath
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata,
	input  logic [1:0] action,
	input  logic [KEY_BITS-1:0] key_tag,
	input  logic [VALUE_BITS-1:0] value_word,
	input  logic signed [TTL_BITS-1:0] ttl_ms,
	input  logic [TIME_BITS-1:0] now_ms,
	output logic [1:0] status,
	output logic [VALUE_BITS-1:0] read_value
);
	localparam int RB = $clog2(MAX_ENTRIES) + 1;
	localparam int IB = $clog2(MAX_ENTRIES);

	logic [CAP_BITS-1:0] cap_q;
	logic [1:0] act_q;
	logic [KEY_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [TIME_BITS-1:0] now_q, dl_q;
	logic exp_q;

	logic [MAX_ENTRIES-1:0] vld_q;
	logic [KEY_BITS-1:0] ekey_q [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] eval_q [MAX_ENTRIES];
	logic [TIME_BITS-1:0] edl_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] eexp_q;
	logic [RB-1:0] rank_q [MAX_ENTRIES];

	// Deadline of a set, computed at acceptance.
	logic [TIME_BITS:0] sum;
	logic [TTL_BITS-1:0] mag;
	logic [TIME_BITS-1:0] dl_d;
	always_comb begin
		sum = {1'b0, now_ms} + {{(TIME_BITS-TTL_BITS+1){1'b0}}, ttl_ms};
		mag = -ttl_ms;
		if (ttl_ms[TTL_BITS-1]) begin
			dl_d = (now_ms >= {{(TIME_BITS-TTL_BITS){1'b0}}, mag}) ?
				now_ms - {{(TIME_BITS-TTL_BITS){1'b0}}, mag} : '0;
		end else begin
			dl_d = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
		end
	end

	// Associative match and slot selection.
	logic [MAX_ENTRIES-1:0] hit_vec;
	logic hit;
	logic [IB-1:0] hs;
	logic [RB-1:0] hr, capm1;
	logic [CAP_BITS-1:0] cap_e;
	logic expired;
	always_comb begin
		hit = 1'b0;
		hs = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i] = vld_q[i] && (ekey_q[i] == key_q);
			if (hit_vec[i]) begin
				hit = 1'b1;
				hs = IB'(i);
			end
		end
		hr = rank_q[hs];
		expired = eexp_q[hs] && (now_q > edl_q[hs]);
		cap_e = (cap_q == '0) ? CAP_BITS'(1) :
			((32'(cap_q) > MAX_ENTRIES) ? CAP_BITS'(MAX_ENTRIES) : cap_q);
		capm1 = RB'(32'(cap_e) - 1);
	end

	// Set: valid entries after dropping the hit and trimming to capacity.
	logic [MAX_ENTRIES-1:0] keep;
	logic [IB-1:0] fs;
	always_comb begin
		fs = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			keep[i] = vld_q[i] && !(hit && IB'(i) == hs) &&
				((hit && rank_q[i] > hr) ? rank_q[i] - 1'b1 : rank_q[i]) < capm1;
		end
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!keep[i]) fs = IB'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.exec) begin
				if (act_q == ACT_SET) begin
					vld_q <= keep | (MAX_ENTRIES'(1) << fs);
				end else if ((act_q == ACT_GET || act_q == ACT_DEL) && hit &&
					(act_q == ACT_DEL || expired)) begin
					vld_q[hs] <= 1'b0;
				end
			end
		end
	end

	// Operand capture and entry payload/rank updates.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			key_q <= key_tag;
			val_q <= value_word;
			now_q <= now_ms;
			dl_q <= dl_d;
			exp_q <= (ttl_ms != '1);
		end
		if (cmd.exec) begin
			unique case (act_q)
				ACT_SET: begin
					status <= ST_DONE;
					read_value <= '0;
					for (int i = 0; i < MAX_ENTRIES; i++) begin
						if (keep[i])
							rank_q[i] <= ((hit && rank_q[i] > hr) ?
								rank_q[i] : rank_q[i] + 1'b1);
					end
					ekey_q[fs] <= key_q;
					eval_q[fs] <= val_q;
					edl_q[fs] <= dl_q;
					eexp_q[fs] <= exp_q;
					rank_q[fs] <= '0;
				end
				ACT_GET, ACT_DEL: begin
					status <= !hit ? ST_ABSENT :
						((act_q == ACT_GET && expired) ? ST_EXPIRED : ST_DONE);
					read_value <= (hit && act_q == ACT_GET && !expired) ? eval_q[hs] : '0;
					if (hit) begin
						if (act_q == ACT_GET && !expired) begin
							for (int i = 0; i < MAX_ENTRIES; i++)
								if (vld_q[i] && rank_q[i] < hr) rank_q[i] <= rank_q[i] + 1'b1;
							rank_q[hs] <= '0;
						end else begin
							for (int i = 0; i < MAX_ENTRIES; i++)
								if (vld_q[i] && rank_q[i] > hr) rank_q[i] <= rank_q[i] - 1'b1;
						end
					end
				end
				default: begin
					status <= ST_ABSENT;
					read_value <= '0;
				end
			endcase
		end
	end
endmodule

// ----- hdl/lru_key_value_cache_with_ttl_core.sv -----
// An item's result is offered once its operands are captured and the S_EXEC
// search-and-update step has run; that single step over all entries, which each
// item needs before the next, bounds how often items can be accepted.
// A waiting result blocks acceptance of the next item until it is taken.
// Reset (arst_n low, asynchronous) empties the store and sets capacity to 16.
module lru_key_value_cache_with_ttl_core
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] action,
	input  logic [KEY_BITS-1:0] key_tag,
	input  logic [VALUE_BITS-1:0] value_word,
	input  logic signed [TTL_BITS-1:0] ttl_ms,
	input  logic [TIME_BITS-1:0] now_ms,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [VALUE_BITS-1:0] read_value
);
	cmd_t cmd;

	// Sequencer.
	lkv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	// Entry store and result register.
	lkv_datapath #(
		.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.action(action), .key_tag(key_tag), .value_word(value_word), .ttl_ms(ttl_ms),
		.now_ms(now_ms), .status(status), .read_value(read_value)
	);
endmodule

// ----- hdl/lkv_checker.sv -----
`include "lru_key_value_cache_with_ttl_core_defines.svh"
module lkv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status
);
	// An accepted item's result must not appear before its S_EXEC step.
	`LKV_ASSERT_NEXT(a_result, in_valid && in_ready, !out_valid, "result too early")
	`LKV_ASSERT_IMPL(a_status, out_valid, status != 2'd3, "bad status code")
	`LKV_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status),
		"result dropped")
endmodule

bind lru_key_value_cache_with_ttl_core lkv_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status)
);
